FILE: hw/rtl/lphs_pkg.sv
// Shared constants, codes and types of the linear probing hash set.
package lphs_pkg;

	// Key and field widths
	localparam int KEY_W   = 64;
	localparam int SLOTS_W = 11;
	localparam int SLOT_W  = 10;

	// Default slot store depth and slot count after reset
	localparam int TABLE_DEPTH_DEF = 1024;
	localparam logic [SLOTS_W-1:0] SLOTS_RESET = 11'd1024;

	// Request operations
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} op_t;

	// Response status codes
	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_FULL      = 2'd2,
		ST_DELETED   = 2'd3
	} status_t;

endpackage

FILE: hw/rtl/lphs_req_if.sv
// Request channel: operation, key and slot words with a valid/ready handshake.
interface lphs_req_if;
	import lphs_pkg::*;

	logic              valid;
	logic              ready;
	logic              operation;
	logic [KEY_W-1:0]  key;
	logic [SLOT_W-1:0] slot;

	modport source (output valid, output operation, output key, output slot, input ready);
	modport sink (input valid, input operation, input key, input slot, output ready);
endinterface

FILE: hw/rtl/lphs_rsp_if.sv
// Response channel: status and result slot words with a valid/ready handshake.
interface lphs_rsp_if;
	import lphs_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [SLOT_W-1:0] result_slot;

	modport source (output valid, output status, output result_slot, input ready);
	modport sink (input valid, input status, input result_slot, output ready);
endinterface

FILE: hw/rtl/lphs_store.sv
// Slot store: one write port and one read port with registered read data.
module lphs_store #(
	parameter int TABLE_DEPTH = lphs_pkg::TABLE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [$clog2(TABLE_DEPTH)-1:0]  waddr,
	input  logic [lphs_pkg::KEY_W-1:0]      wdata,
	input  logic [$clog2(TABLE_DEPTH)-1:0]  raddr,
	output logic [lphs_pkg::KEY_W-1:0]      rdata
);
	import lphs_pkg::*;

	logic [KEY_W-1:0] mem [TABLE_DEPTH];

	// Read data is registered and appears in the cycle after the read address; a read of the slot written in the
	// same cycle returns the old key.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: hw/rtl/lphs_hash.sv
// Hash unit: high word of key times slot count, in two registered stages.
module lphs_hash #(
	parameter int TABLE_DEPTH = lphs_pkg::TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic [lphs_pkg::KEY_W-1:0]        key,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0]  n,
	output logic [$clog2(TABLE_DEPTH)-1:0]    idx_s2
);
	import lphs_pkg::*;

	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int HALF_W = KEY_W / 2;
	localparam int PROD_W = HALF_W + CNT_W;

	logic [PROD_W-1:0] p_lo_s1;
	logic [PROD_W-1:0] p_hi_s1;
	logic [CNT_W-1:0]  n_s1;
	logic [PROD_W:0]   sum;
	logic [CNT_W:0]    idx_raw;
	logic [CNT_W-1:0]  n_m1;
	logic [IDX_W-1:0]  idx_clamp;

	// Stage 1: the two half-word partial products.
	always_ff @(posedge clk) begin
		p_lo_s1 <= PROD_W'(key[HALF_W-1:0]) * PROD_W'(n);
		p_hi_s1 <= PROD_W'(key[KEY_W-1:HALF_W]) * PROD_W'(n);
		n_s1    <= n;
	end

	// Stage 2: combine the partial products and keep the start slot below n.
	always_comb begin
		sum     = (PROD_W+1)'(p_hi_s1) + (PROD_W+1)'(p_lo_s1[PROD_W-1:HALF_W]);
		idx_raw = sum[PROD_W:HALF_W];
		n_m1    = n_s1 - CNT_W'(1);
		if (idx_raw >= (CNT_W+1)'(n_s1)) begin
			idx_clamp = n_m1[IDX_W-1:0];
		end else begin
			idx_clamp = idx_raw[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		idx_s2 <= idx_clamp;
	end
endmodule

FILE: hw/rtl/lphs_ctrl.sv
// Controller: clearing pass, request decode, probe walk and response register.
module lphs_ctrl #(
	parameter int TABLE_DEPTH = lphs_pkg::TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	lphs_req_if.sink                          req,
	lphs_rsp_if.source                        rsp,
	input  logic                              cfg_we,
	input  logic [lphs_pkg::SLOTS_W-1:0]      cfg_wdata,
	output logic [$clog2(TABLE_DEPTH+1)-1:0]  n_eff,
	input  logic [$clog2(TABLE_DEPTH)-1:0]    hash_idx,
	output logic                              mem_we,
	output logic [$clog2(TABLE_DEPTH)-1:0]    mem_waddr,
	output logic [lphs_pkg::KEY_W-1:0]        mem_wdata,
	output logic [$clog2(TABLE_DEPTH)-1:0]    mem_raddr,
	input  logic [lphs_pkg::KEY_W-1:0]        mem_rdata
);
	import lphs_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CMP_W = (CNT_W > SLOTS_W) ? CNT_W : SLOTS_W;
	localparam int SW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
	localparam int AW    = (SW > 32) ? SW : 32;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_H1    = 6'b000100,
		S_H2    = 6'b001000,
		S_PROBE = 6'b010000,
		S_RESP  = 6'b100000
	} state_t;

	state_t            state_q, state_d;
	logic [SLOTS_W-1:0] slots_q;
	logic [IDX_W-1:0]  clr_q;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [CNT_W-1:0]  probes_q, probes_d;
	logic [KEY_W-1:0]  key_q;
	logic [CNT_W-1:0]  n_q;
	status_t           res_status_q, res_status;
	logic [SLOT_W-1:0] res_slot_q, res_slot;
	logic              rsp_valid_q;
	status_t           rsp_status_q;
	logic [SLOT_W-1:0] rsp_slot_q;

	logic [CMP_W-1:0]  slots_ext, n_cmp;
	logic              req_fire, rsp_free, done, load_rsp, del_ok;
	logic [SW-1:0]     slot_ext, idx_ext;
	logic [CNT_W-1:0]  idx_p1, probes_p1;
	logic [IDX_W-1:0]  idx_inc;

	// Effective slot count: the register saturated into one to the store depth.
	always_comb begin
		slots_ext = CMP_W'(slots_q);
		if (slots_ext == '0) begin
			n_cmp = CMP_W'(1);
		end else if (slots_ext > CMP_W'(TABLE_DEPTH)) begin
			n_cmp = CMP_W'(TABLE_DEPTH);
		end else begin
			n_cmp = slots_ext;
		end
		n_eff = n_cmp[CNT_W-1:0];
	end

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	// Slot and index conversions between the 10-bit fields and the store index.
	always_comb begin
		slot_ext  = SW'(req.slot);
		del_ok    = AW'(req.slot) < AW'(TABLE_DEPTH);
		idx_ext   = SW'(idx_q);
		idx_p1    = CNT_W'(idx_q) + CNT_W'(1);
		probes_p1 = probes_q + CNT_W'(1);
		idx_inc   = (idx_p1 == n_q) ? '0 : idx_p1[IDX_W-1:0];
	end

	// Next state, store access and result selection.
	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		probes_d   = probes_q;
		mem_we     = 1'b0;
		mem_waddr  = idx_q;
		mem_wdata  = key_q;
		mem_raddr  = idx_q;
		done       = 1'b0;
		load_rsp   = 1'b0;
		res_status = ST_FULL;
		res_slot   = '0;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == LAST_IDX) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_fire) begin
					if (req.operation == OP_DELETE) begin
						mem_we     = del_ok;
						mem_waddr  = slot_ext[IDX_W-1:0];
						mem_wdata  = '0;
						done       = 1'b1;
						res_status = ST_DELETED;
					end else begin
						state_d = S_H1;
					end
				end
			end
			S_H1: begin
				state_d = S_H2;
			end
			S_H2: begin
				mem_raddr = hash_idx;
				idx_d     = hash_idx;
				probes_d  = '0;
				state_d   = S_PROBE;
			end
			S_PROBE: begin
				if (mem_rdata == '0) begin
					mem_we     = 1'b1;
					done       = 1'b1;
					res_status = ST_INSERTED;
					res_slot   = idx_ext[SLOT_W-1:0];
				end else if (mem_rdata == key_q) begin
					done       = 1'b1;
					res_status = ST_DUPLICATE;
				end else if (probes_p1 == n_q) begin
					done       = 1'b1;
					res_status = ST_FULL;
				end else begin
					idx_d     = idx_inc;
					mem_raddr = idx_inc;
					probes_d  = probes_p1;
				end
			end
			S_RESP: begin
				res_status = res_status_q;
				res_slot   = res_slot_q;
				if (rsp_free) begin
					load_rsp = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// A finished word goes straight out when the response register is free.
		if (done) begin
			if (rsp_free) begin
				load_rsp = 1'b1;
				state_d  = S_IDLE;
			end else begin
				state_d = S_RESP;
			end
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			slots_q     <= SLOTS_RESET;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				slots_q <= cfg_wdata;
			end
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		probes_q <= probes_d;
		if (req_fire) begin
			key_q <= req.key;
			n_q   <= n_eff;
		end
		if (done) begin
			res_status_q <= res_status;
			res_slot_q   <= res_slot;
		end
		if (load_rsp) begin
			rsp_status_q <= res_status;
			rsp_slot_q   <= res_slot;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.result_slot = rsp_slot_q;

	// The probe walk never runs past one full round of the slots in use.
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PROBE |-> probes_q < n_q)
		else $error("probe count reached slot count");

	// The probed slot stays inside the slots in use.
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PROBE |-> CNT_W'(idx_q) < n_q)
		else $error("probe index outside slots in use");

	// A new response never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_rsp |-> (!rsp_valid_q || rsp.ready))
		else $error("response overwritten while stalled");

	// No request is taken during the clearing pass.
	a_clear_closed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |=> !(req.valid && req.ready) || $past(clr_q) == LAST_IDX)
		else $error("request taken during clearing pass");
endmodule

FILE: hw/rtl/linear_probe_hash_set_top.sv
// Top level of the linear probing hash set: hash unit, controller and slot store.
//
// Usage: requests arrive on req (operation, key, slot), one response word per
// request leaves on rsp (status, result_slot). Both use valid/ready; a word
// moves at a clock edge with valid and ready high. slots_in_use is to be written
// through cfg_we/cfg_wdata while the block is idle; the block does not enforce it.
// An insert probes k slots between acceptance and a valid response, where k is
// 1 up to the slots in use; each probe is one read of the single-port-read slot
// store, and the two hash multiply stages come first. A delete is finished in
// the cycle it is accepted. The block takes one request at a time; the next
// request is taken the cycle after the response is registered.
// Reset: after arst_n is released the store is cleared one slot per cycle, all
// TABLE_DEPTH slots, with req.ready low; configuration writes are taken.
// Stall: a response waits in the output register while rsp.ready is low; the
// block still accepts one more request, and holds that one's result until the
// register is free.
module linear_probe_hash_set_top #(
	parameter int TABLE_DEPTH = lphs_pkg::TABLE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	lphs_req_if.sink                     req,
	lphs_rsp_if.source                   rsp,
	input  logic                         cfg_we,
	input  logic [lphs_pkg::SLOTS_W-1:0] cfg_wdata
);
	import lphs_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = $clog2(TABLE_DEPTH);

	logic [CNT_W-1:0] n_eff;
	logic [IDX_W-1:0] hash_idx;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [KEY_W-1:0] mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	logic [KEY_W-1:0] mem_rdata;

	// Start slot from the accepted key.
	lphs_hash #(.TABLE_DEPTH(TABLE_DEPTH)) u_hash (
		.clk    (clk),
		.key    (req.key),
		.n      (n_eff),
		.idx_s2 (hash_idx)
	);

	// Sequencing of clear, probe walk and responses.
	lphs_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.n_eff     (n_eff),
		.hash_idx  (hash_idx),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Key storage.
	lphs_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);
endmodule
